// ===== sv/bam_pkg.sv =====
// bam_pkg: shared constants, widths and types for the buoy approach mission controller.
// No dependencies. Used by every file under sv/.
package bam_pkg;

   localparam int FRAME_WIDTH = 410;

   localparam int X_W     = 10;
   localparam int RANGE_W = 16;
   localparam int ERR_W   = 11;
   localparam int MAG_W   = 10;
   localparam int CB_W    = 8;
   localparam int LIM_W   = 14;
   localparam int TOP_W   = 16;
   localparam int PROD_W  = MAG_W + TOP_W;
   localparam int NUM_W   = PROD_W + 1;
   localparam int DEN_W   = 10;
   localparam int CNT_W   = 5;
   localparam int FWD_W   = 17;
   localparam int TURN_W  = 24;
   localparam int THIRD_W = 7;
   localparam int CSR_A_W = 2;
   localparam int CSR_D_W = 16;
   localparam int REQ_D_W = 32;
   localparam int RSP_D_W = 48;

   localparam logic [ERR_W-1:0] HALF_FRAME = ERR_W'(FRAME_WIDTH / 2);

   // x/3 == (x*171)>>9 for 8-bit x; x/3 == (x*43691)>>17 for 17-bit x
   localparam logic [CB_W:0]  RECIP3_CB  = 9'd171;
   localparam logic [FWD_W-1:0] RECIP3_TOP = 17'd43691;

   localparam logic [NUM_W-1:0]  SAT_POS_LIM = NUM_W'(8388607);
   localparam logic [NUM_W-1:0]  SAT_NEG_LIM = NUM_W'(8388608);
   localparam logic [TURN_W-1:0] TURN_MAX    = 24'h7FFFFF;
   localparam logic [TURN_W-1:0] TURN_MIN    = 24'h800000;

   typedef enum logic [CSR_A_W-1:0] {
      REG_CENTER_BAND = 2'd0,
      REG_RANGE_LOW   = 2'd1,
      REG_RANGE_HIGH  = 2'd2,
      REG_TOP_SPEED   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_SEARCH   = 2'd0,
      PH_ALIGN    = 2'd1,
      PH_APPROACH = 2'd2,
      PH_REVERSE  = 2'd3
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CALC = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

endpackage

// ===== sv/bam_div.sv =====
// bam_div: restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on bam_pkg for operand widths.
module bam_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bam_pkg::NUM_W-1:0]     num,
   input  logic [bam_pkg::DEN_W-1:0]     den,
   output logic                          done,
   output logic [bam_pkg::NUM_W-1:0]     quo
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [bam_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [bam_pkg::DEN_W-1:0]     rem_ff, rem_in;
   logic [bam_pkg::DEN_W-1:0]     den_ff, den_in;
   logic [bam_pkg::NUM_W-1:0]     quo_ff, quo_in;
   logic [bam_pkg::DEN_W:0]       trial;
   logic [bam_pkg::DEN_W:0]       diff;
   logic                          ge;

   assign trial = {rem_ff, quo_ff[bam_pkg::NUM_W-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = bam_pkg::CNT_W'(bam_pkg::NUM_W - 1);
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
      end else if (busy_ff) begin
         rem_in = ge ? diff[bam_pkg::DEN_W-1:0] : trial[bam_pkg::DEN_W-1:0];
         quo_in = {quo_ff[bam_pkg::NUM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== sv/buoy_approach_mission_controller.sv =====
// buoy_approach_mission_controller: mission phase machine with forward and turn drive.
// Depends on bam_pkg and bam_div.
//
// One beat in, one beat out. A request is taken only while the block is idle; the calc
// state then forms the phase transition, error product and forward drive, and in align,
// approach and reverse the shared bit-serial divider (27 quotient bits) forms the turn
// drive; in search phase or with a zero band the divider is skipped. The result beat
// is held until rsp_tready; the next request is taken the cycle after the result beat.
// Registers are to be written through the csr port only while no item is in flight;
// the block itself does not enforce this.
module buoy_approach_mission_controller (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bam_pkg::REQ_D_W-1:0]     req_tdata,  // target_x, range_mm
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bam_pkg::RSP_D_W-1:0]     rsp_tdata,  // phase, forward_drive, turn_drive
   input  logic                            csr_we,
   input  logic [bam_pkg::CSR_A_W-1:0]     csr_addr,
   input  logic [bam_pkg::CSR_D_W-1:0]     csr_wdata
);

   bam_pkg::state_type              state_ff, state_in;
   bam_pkg::phase_type              phase_ff, phase_in;

   logic [bam_pkg::CB_W-1:0]        cb_ff;
   logic [bam_pkg::THIRD_W-1:0]     cb_third_ff;
   logic [bam_pkg::LIM_W-1:0]       lim_low_ff;
   logic [bam_pkg::LIM_W-1:0]       lim_high_ff;
   logic [bam_pkg::TOP_W-1:0]       top_ff;

   logic [bam_pkg::X_W-1:0]         x_ff;
   logic [bam_pkg::RANGE_W-1:0]     range_ff;
   logic                            neg_ff, neg_in;
   logic [bam_pkg::FWD_W-1:0]       fwd_ff, fwd_in;
   logic [bam_pkg::TURN_W-1:0]      turn_ff, turn_in;

   logic [(2*bam_pkg::CB_W)+1-1:0]  cb_third_prod;
   logic signed [bam_pkg::ERR_W-1:0] err;
   logic [bam_pkg::ERR_W-1:0]       err_abs;
   logic [bam_pkg::MAG_W-1:0]       mag;
   logic                            centred;
   logic                            near;
   logic [bam_pkg::PROD_W-1:0]      prod;
   logic [2*bam_pkg::FWD_W-1:0]     rev_prod;
   logic [bam_pkg::FWD_W-1:0]       rev_mag;
   logic [bam_pkg::NUM_W-1:0]       div_num;
   logic [bam_pkg::DEN_W-1:0]       div_den;
   logic                            div_start;
   logic                            div_done;
   logic [bam_pkg::NUM_W-1:0]       div_quo;
   logic [bam_pkg::NUM_W-1:0]       quo_neg;

   assign cb_third_prod = csr_wdata[bam_pkg::CB_W-1:0] * bam_pkg::RECIP3_CB;

   always_ff @(posedge clock) begin
      if (reset) begin
         cb_ff       <= 8'd200;
         cb_third_ff <= 7'd66;
         lim_low_ff  <= 14'd500;
         lim_high_ff <= 14'd1500;
         top_ff      <= 16'd3840;
      end else if (csr_we) begin
         unique case (bam_pkg::csr_index_type'(csr_addr))
            bam_pkg::REG_CENTER_BAND: begin
               cb_ff       <= csr_wdata[bam_pkg::CB_W-1:0];
               cb_third_ff <= cb_third_prod[bam_pkg::CB_W+bam_pkg::THIRD_W:bam_pkg::CB_W+1];
            end
            bam_pkg::REG_RANGE_LOW:  lim_low_ff  <= csr_wdata[bam_pkg::LIM_W-1:0];
            bam_pkg::REG_RANGE_HIGH: lim_high_ff <= csr_wdata[bam_pkg::LIM_W-1:0];
            bam_pkg::REG_TOP_SPEED:  top_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign err     = $signed(bam_pkg::HALF_FRAME) - $signed({1'b0, x_ff});
   assign err_abs = err[bam_pkg::ERR_W-1] ? (-err) : err;
   assign mag     = err_abs[bam_pkg::MAG_W-1:0];
   assign centred = mag < {2'b00, cb_ff};
   assign near    = mag < {3'b000, cb_third_ff};
   assign prod    = mag * top_ff;
   assign rev_prod = {top_ff, 1'b0} * bam_pkg::RECIP3_TOP;
   assign rev_mag  = rev_prod[2*bam_pkg::FWD_W-1:bam_pkg::FWD_W];
   assign quo_neg  = -div_quo;

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         bam_pkg::PH_SEARCH: begin
            if (centred) phase_in = bam_pkg::PH_ALIGN;
         end
         bam_pkg::PH_ALIGN: begin
            if (near) phase_in = bam_pkg::PH_APPROACH;
            else if (!centred) phase_in = bam_pkg::PH_SEARCH;
         end
         bam_pkg::PH_APPROACH: begin
            if (range_ff < {2'b00, lim_low_ff}) phase_in = bam_pkg::PH_REVERSE;
            else if (!centred) phase_in = bam_pkg::PH_SEARCH;
         end
         bam_pkg::PH_REVERSE: begin
            if (range_ff > {2'b00, lim_high_ff} || !centred) phase_in = bam_pkg::PH_SEARCH;
         end
         default: phase_in = bam_pkg::PH_SEARCH;
      endcase
   end

   always_comb begin
      if (phase_in == bam_pkg::PH_ALIGN) begin
         div_num = {1'b0, prod};
         div_den = {1'b0, cb_ff, 1'b0};
      end else begin
         div_num = {prod, 1'b0};
         div_den = {2'b00, cb_ff} + {1'b0, cb_ff, 1'b0};
      end
   end

   always_comb begin
      state_in  = state_ff;
      neg_in    = neg_ff;
      fwd_in    = fwd_ff;
      turn_in   = turn_ff;
      div_start = 1'b0;
      unique case (state_ff)
         bam_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = bam_pkg::ST_CALC;
         end
         bam_pkg::ST_CALC: begin
            neg_in = !err[bam_pkg::ERR_W-1] && (err != '0);
            unique case (phase_in)
               bam_pkg::PH_APPROACH: fwd_in = {2'b00, top_ff[bam_pkg::TOP_W-1:1]};
               bam_pkg::PH_REVERSE:  fwd_in = -rev_mag;
               default:              fwd_in = '0;
            endcase
            if (phase_in == bam_pkg::PH_SEARCH) begin
               turn_in  = {9'd0, top_ff[bam_pkg::TOP_W-1:1]};
               state_in = bam_pkg::ST_DONE;
            end else if (cb_ff == '0) begin
               turn_in  = '0;
               state_in = bam_pkg::ST_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = bam_pkg::ST_DIV;
            end
         end
         bam_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = bam_pkg::ST_DONE;
               if (neg_ff) begin
                  turn_in = (div_quo > bam_pkg::SAT_NEG_LIM) ? bam_pkg::TURN_MIN
                                                             : quo_neg[bam_pkg::TURN_W-1:0];
               end else begin
                  turn_in = (div_quo > bam_pkg::SAT_POS_LIM) ? bam_pkg::TURN_MAX
                                                             : div_quo[bam_pkg::TURN_W-1:0];
               end
            end
         end
         bam_pkg::ST_DONE: begin
            if (rsp_tready) state_in = bam_pkg::ST_IDLE;
         end
         default: state_in = bam_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bam_pkg::ST_IDLE;
         phase_ff <= bam_pkg::PH_SEARCH;
      end else begin
         state_ff <= state_in;
         if (state_ff == bam_pkg::ST_CALC) phase_ff <= phase_in;
      end
      if (state_ff == bam_pkg::ST_IDLE && req_tvalid) begin
         x_ff     <= req_tdata[bam_pkg::X_W-1:0];
         range_ff <= req_tdata[bam_pkg::X_W+bam_pkg::RANGE_W-1:bam_pkg::X_W];
      end
      neg_ff  <= neg_in;
      fwd_ff  <= fwd_in;
      turn_ff <= turn_in;
   end

   bam_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign req_tready = (state_ff == bam_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == bam_pkg::ST_DONE);
   assign rsp_tdata  = {5'd0, turn_ff, fwd_ff, phase_ff};

endmodule

// ===== sv/bam_checker.sv =====
// bam_checker: port-level assertions for the mission controller, bound to the top level.
// Depends on bam_pkg for port widths.
module bam_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bam_pkg::RSP_D_W-1:0]     rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req taken while an item is in flight");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("req ready while a result beat waits");

   a_fwd_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] == bam_pkg::PH_SEARCH ||
                     rsp_tdata[1:0] == bam_pkg::PH_ALIGN) |->
      rsp_tdata[18:2] == 17'd0)
      else $error("forward drive nonzero in search or align");

   a_fwd_approach: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == bam_pkg::PH_APPROACH |-> !rsp_tdata[18])
      else $error("negative forward drive in approach");

endmodule

bind buoy_approach_mission_controller bam_checker u_bam_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
